FILE: rtl/led_blink_pattern_sequencer_macros.svh
// Assertion macros for the LED blink pattern sequencer.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LED_BLINK_PATTERN_SEQUENCER_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// The consequent holds in the same cycle as the antecedent.
`define LBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbps assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

`else

`define LBPS_ASSERT_NOW(label, ante, cons)
`define LBPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/lbps_pkg.sv
`default_nettype none

package lbps_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int PERIOD_W        = 16;
    localparam int CODE_W          = 3;
    localparam int IDX_W           = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

    // Pattern codes carried by an append item.
    localparam logic [CODE_W-1:0] PAT_BLINK0     = 3'd0;
    localparam logic [CODE_W-1:0] PAT_BLINK1     = 3'd1;
    localparam logic [CODE_W-1:0] PAT_BOTH3      = 3'd2;
    localparam logic [CODE_W-1:0] PAT_ENC_ERROR  = 3'd3;
    localparam logic [CODE_W-1:0] PAT_DEC_ERROR  = 3'd4;

    // Request kinds.
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_APPEND = 1'b1;

    typedef enum logic [2:0] {
        STEP_ON0    = 3'd0,
        STEP_OFF0   = 3'd1,
        STEP_ON1    = 3'd2,
        STEP_OFF1   = 3'd3,
        STEP_ONALL  = 3'd4,
        STEP_OFFALL = 3'd5
    } step_t;

    typedef struct packed {
        logic              req_type;
        logic [CODE_W-1:0] pattern_code;
    } req_t;

    typedef struct packed {
        logic led0_lit;
        logic led1_lit;
        logic pattern_dropped;
    } flags_t;

    // Number of steps a pattern expands into; zero for unknown codes.
    function automatic logic [IDX_W-1:0] pattern_len(input logic [CODE_W-1:0] code);
        logic [IDX_W-1:0] len;
        unique case (code)
            PAT_BLINK0, PAT_BLINK1:                  len = 3'd2;
            PAT_BOTH3, PAT_ENC_ERROR, PAT_DEC_ERROR: len = 3'd6;
            default:                                 len = 3'd0;
        endcase
        return len;
    endfunction

    // Step at position idx of a pattern.
    function automatic step_t pattern_step(input logic [CODE_W-1:0] code,
                                           input logic [IDX_W-1:0]  idx);
        step_t s;
        unique case (code)
            PAT_BLINK0: s = (idx == 3'd0) ? STEP_ON0 : STEP_OFF0;
            PAT_BLINK1: s = (idx == 3'd0) ? STEP_ON1 : STEP_OFF1;
            PAT_BOTH3:  s = idx[0] ? STEP_OFFALL : STEP_ONALL;
            PAT_ENC_ERROR:
            begin
                if (idx == 3'd0)
                    s = STEP_ONALL;
                else if (idx == 3'd5)
                    s = STEP_OFFALL;
                else
                    s = idx[0] ? STEP_OFF0 : STEP_ON0;
            end
            PAT_DEC_ERROR:
            begin
                if (idx == 3'd0)
                    s = STEP_ONALL;
                else if (idx == 3'd5)
                    s = STEP_OFFALL;
                else
                    s = idx[0] ? STEP_OFF1 : STEP_ON1;
            end
            default: s = STEP_OFFALL;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lbps_if.sv
`default_nettype none

// Request channel: ticks and pattern appends.
interface lbps_req_if;
    import lbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CODE_W-1:0] pattern_code;

    modport source (output valid, output req_type, output pattern_code, input ready);
    modport sink   (input valid, input req_type, input pattern_code, output ready);
endinterface

// Result channel: LED states, drop flag and queue fill.
interface lbps_rsp_if #(parameter int CNT_W = $clog2(lbps_pkg::QUEUE_DEPTH_DEF + 1));
    logic             valid;
    logic             ready;
    logic             led0_lit;
    logic             led1_lit;
    logic             pattern_dropped;
    logic [CNT_W-1:0] steps_pending;

    modport source (output valid, output led0_lit, output led1_lit,
                    output pattern_dropped, output steps_pending, input ready);
    modport sink   (input valid, input led0_lit, input led1_lit,
                    input pattern_dropped, input steps_pending, output ready);
endinterface

// Configuration channel: step period write.
interface lbps_cfg_if;
    import lbps_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] step_period;

    modport source (output valid, output step_period, input ready);
    modport sink   (input valid, input step_period, output ready);
endinterface

`default_nettype wire

FILE: rtl/lbps_ram.sv
`default_nettype none

module lbps_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same address is written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/lbps_core.sv
`default_nettype none

`include "led_blink_pattern_sequencer_macros.svh"

module lbps_core #(
    parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  fire,
    input  wire lbps_pkg::req_t                        req,
    input  wire logic [lbps_pkg::PERIOD_W-1:0]         step_period,
    output lbps_pkg::flags_t                           flags,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0]      steps_pending
);
    import lbps_pkg::*;

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    // Each queued pattern holds at least two steps.
    localparam int PAT_DEPTH = (QUEUE_DEPTH + 1) / 2;
    localparam int PTR_W     = $clog2(PAT_DEPTH);

    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(PAT_DEPTH - 1);
    localparam logic [CNT_W:0]     CNT_LIMIT = (CNT_W + 1)'(QUEUE_DEPTH);

    logic [CNT_W-1:0]    step_cnt_reg,  step_cnt_next;
    logic [PTR_W-1:0]    pat_head_reg,  pat_head_next;
    logic [PTR_W-1:0]    pat_tail_reg,  pat_tail_next;
    logic [IDX_W-1:0]    step_idx_reg,  step_idx_next;
    logic [PERIOD_W-1:0] tick_reg,      tick_next;
    logic                led0_reg,      led0_next;
    logic                led1_reg,      led1_next;
    logic                byp_valid_reg, byp_valid_next;
    logic [CODE_W-1:0]   byp_code_reg;

    logic [CODE_W-1:0]   rd_code;
    logic [CODE_W-1:0]   front_code;
    logic [IDX_W-1:0]    new_len;
    logic [IDX_W-1:0]    front_last;
    logic                front_done;
    step_t               cur_step;
    logic                is_append;
    logic                is_known;
    logic                fits;
    logic                do_push;
    logic                dropped;
    logic                is_tick;
    logic                do_pop;

    // Pattern codes are queued, one entry per append; steps are expanded on pop.
    lbps_ram #(
        .WIDTH (CODE_W),
        .DEPTH (PAT_DEPTH)
    ) u_pat_ram (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (pat_tail_reg),
        .wr_data (req.pattern_code),
        .rd_addr (pat_head_next),
        .rd_data (rd_code)
    );

    // A pattern written into the slot being read this cycle comes from the bypass.
    assign front_code = byp_valid_reg ? byp_code_reg : rd_code;

    always_comb
    begin
        new_len    = pattern_len(req.pattern_code);
        is_append  = fire && (req.req_type == REQ_APPEND);
        is_known   = (new_len != 3'd0);
        fits       = ({1'b0, step_cnt_reg} + (CNT_W + 1)'(new_len)) <= CNT_LIMIT;
        do_push    = is_append && is_known && fits;
        dropped    = is_append && is_known && !fits;

        is_tick    = fire && (req.req_type == REQ_TICK) && (step_cnt_reg != '0);
        do_pop     = is_tick && (tick_reg >= step_period);

        cur_step   = pattern_step(front_code, step_idx_reg);
        front_last = pattern_len(front_code) - 3'd1;
        front_done = (step_idx_reg == front_last);

        tick_next = tick_reg;
        if (do_pop)
            tick_next = '0;
        else if (is_tick)
            tick_next = tick_reg + 16'd1;

        led0_next = led0_reg;
        led1_next = led1_reg;
        if (do_pop)
        begin
            case (cur_step) inside
                STEP_ON0:    led0_next = 1'b1;
                STEP_OFF0:   led0_next = 1'b0;
                STEP_ON1:    led1_next = 1'b1;
                STEP_OFF1:   led1_next = 1'b0;
                STEP_ONALL:
                begin
                    led0_next = 1'b1;
                    led1_next = 1'b1;
                end
                STEP_OFFALL:
                begin
                    led0_next = 1'b0;
                    led1_next = 1'b0;
                end
                default: ;
            endcase
        end

        step_idx_next = step_idx_reg;
        pat_head_next = pat_head_reg;
        if (do_pop)
        begin
            if (front_done)
            begin
                step_idx_next = '0;
                pat_head_next = (pat_head_reg == PTR_LAST) ? '0 : pat_head_reg + 1'b1;
            end
            else
            begin
                step_idx_next = step_idx_reg + 3'd1;
            end
        end

        pat_tail_next = pat_tail_reg;
        if (do_push)
            pat_tail_next = (pat_tail_reg == PTR_LAST) ? '0 : pat_tail_reg + 1'b1;

        step_cnt_next = step_cnt_reg;
        if (do_push)
            step_cnt_next = step_cnt_reg + CNT_W'(new_len);
        else if (do_pop)
            step_cnt_next = step_cnt_reg - 1'b1;

        byp_valid_next = do_push && (pat_tail_reg == pat_head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg  <= '0;
            pat_head_reg  <= '0;
            pat_tail_reg  <= '0;
            step_idx_reg  <= '0;
            tick_reg      <= '0;
            led0_reg      <= 1'b0;
            led1_reg      <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            step_cnt_reg  <= step_cnt_next;
            pat_head_reg  <= pat_head_next;
            pat_tail_reg  <= pat_tail_next;
            step_idx_reg  <= step_idx_next;
            tick_reg      <= tick_next;
            led0_reg      <= led0_next;
            led1_reg      <= led1_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_code_reg <= req.pattern_code;
    end

    assign flags.led0_lit        = led0_next;
    assign flags.led1_lit        = led1_next;
    assign flags.pattern_dropped = dropped;
    assign steps_pending         = step_cnt_next;

    `LBPS_ASSERT_NOW(a_cnt_bound, 1'b1, step_cnt_reg <= CNT_W'(QUEUE_DEPTH))
    `LBPS_ASSERT_NOW(a_empty_aligned, step_cnt_reg == '0, (pat_head_reg == pat_tail_reg) && (step_idx_reg == '0))
    `LBPS_ASSERT_NOW(a_push_pop_excl, do_push, !do_pop)
    `LBPS_ASSERT_NEXT(a_drop_keeps, dropped, step_cnt_reg == $past(step_cnt_reg))

endmodule

`default_nettype wire

FILE: rtl/led_blink_pattern_sequencer.sv
`default_nettype none

// Channel   Dir   Handshake        Payload
// cfg       in    valid / ready    step_period (16 bit)
// req       in    valid / ready    req_type, pattern_code
// rsp       out   valid / ready    led0_lit, led1_lit, pattern_dropped, steps_pending
//
// An item waits in the input register; when it leaves, the queue, tick count and
// LEDs advance and the result register loads at the same edge, so a result is offered
// from the result register, and a new item can enter each cycle while rsp is not stalled.
// rst_n clears the queue pointers, tick count, LEDs and sets step_period to 100.
// A stalled result register holds the sequencing logic, and the input register then
// fills and drops req.ready until rsp.ready returns.

module led_blink_pattern_sequencer #(
    parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    lbps_cfg_if.sink   cfg,
    lbps_req_if.sink   req,
    lbps_rsp_if.source rsp
);
    import lbps_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Step period register; the host writes it only while the block is idle (not enforced here).
    logic [PERIOD_W-1:0] period_reg;

    // Input register stage.
    logic   in_vld_reg, in_vld_next;
    req_t   in_req_reg;

    // Result register stage.
    logic             out_vld_reg, out_vld_next;
    flags_t           out_flags_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    flags_t           core_flags;
    logic [CNT_W-1:0] core_cnt;
    logic             proc_fire;
    logic             req_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            period_reg <= cfg.step_period;
        end
    end

    // The item in the input register is processed once the result register
    // is free or is being emptied in this cycle.
    assign proc_fire = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || proc_fire;
    assign req_take  = req.valid && req.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (req_take)
            in_vld_next = 1'b1;
        else if (proc_fire)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (proc_fire)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_req_reg.req_type     <= req.req_type;
            in_req_reg.pattern_code <= req.pattern_code;
        end
        if (proc_fire)
        begin
            out_flags_reg <= core_flags;
            out_cnt_reg   <= core_cnt;
        end
    end

    // Queue, tick counter and LED state all advance in the cycle the item
    // leaves the input register.
    lbps_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (proc_fire),
        .req           (in_req_reg),
        .step_period   (period_reg),
        .flags         (core_flags),
        .steps_pending (core_cnt)
    );

    assign rsp.valid           = out_vld_reg;
    assign rsp.led0_lit        = out_flags_reg.led0_lit;
    assign rsp.led1_lit        = out_flags_reg.led1_lit;
    assign rsp.pattern_dropped = out_flags_reg.pattern_dropped;
    assign rsp.steps_pending   = out_cnt_reg;

endmodule

`default_nettype wire
